[sv/spt_pkg.sv]
package spt_pkg;

    localparam int DEF_CAPACITY = 16;

    localparam int MODE_W   = 2;
    localparam int ID_W     = 16;
    localparam int PRI_W    = 8;
    localparam int STATUS_W = 2;

    // request codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_PUT,
        S_REM_SCAN,
        S_RD,
        S_RESP
    } state_t;

endpackage

[sv/sorted_priority_table_core.sv]
// Channel  | Ports                                        | Direction
// ---------+----------------------------------------------+----------
// request  | s_valid s_ready s_mode s_entry_id             | in
//          | s_priority_req                               |
// result   | m_valid m_ready m_status m_out_id            | out
//          | m_out_priority m_last                        |
//
// Flow: one request at a time. Insert scans from the tail, moving each entry
// of lower or equal priority up one place, then writes the new entry; a full
// table answers ST_FULL without a scan. Remove scans every entry from the
// head and slides those past the match down; readout delivers one entry per
// cycle while m_ready stays high. Memory: one write port, one registered read.
// Reset: aresetn low clears the entry count, FSM and output valid; the entry
// memory is not cleared, entries beyond the count are never read.
// Stalls: a held result blocks readout entries and the next final result; a
// new request is taken while the previous result waits in the output stage.
module sorted_priority_table_core
    import spt_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [MODE_W-1:0]   s_mode,
    input  logic [ID_W-1:0]     s_entry_id,
    input  logic [PRI_W-1:0]    s_priority_req,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [ID_W-1:0]     m_out_id,
    output logic [PRI_W-1:0]    m_out_priority,
    output logic                m_last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // entry memory: one write port, one registered read port
    entry_t          mem [CAPACITY];
    entry_t          rdata_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    entry_t          mem_wd;
    logic            mem_re;
    logic [AW-1:0]   mem_ra;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic            found_reg, found_next;
    logic [ID_W-1:0] op_id_reg, op_id_next;
    logic [PRI_W-1:0] op_pri_reg, op_pri_next;
    logic [STATUS_W-1:0] st_reg, st_next;

    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [ID_W-1:0]     m_id_reg, m_id_next;
    logic [PRI_W-1:0]    m_pri_reg, m_pri_next;
    logic                m_last_reg, m_last_next;

    logic          out_free;
    logic [AW-1:0] last_idx;
    logic          is_full;
    logic          is_empty;
    logic          id_match;
    logic          ins_stop;
    entry_t        new_entry;

    assign out_free  = !m_valid_reg || m_ready;
    assign last_idx  = AW'(count_reg - CW'(1));
    assign is_full   = (count_reg == CW'(CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign id_match  = (rdata_reg.id == op_id_reg);
    // scan from the tail stops at the first entry of strictly greater priority
    assign ins_stop  = (rdata_reg.pri > op_pri_reg);
    assign new_entry = '{id: op_id_reg, pri: op_pri_reg};

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_out_id       = m_id_reg;
    assign m_out_priority = m_pri_reg;
    assign m_last         = m_last_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_ra];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (s_mode) inside
                        MODE_INSERT: begin
                            if (is_full)       state_next = S_RESP;
                            else if (is_empty) state_next = S_INS_PUT;
                            else               state_next = S_INS_SCAN;
                        end
                        MODE_REMOVE, MODE_READ: begin
                            if (is_empty)                   state_next = S_RESP;
                            else if (s_mode == MODE_REMOVE) state_next = S_REM_SCAN;
                            else                            state_next = S_RD;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_INS_SCAN: begin
                if (ins_stop)                 state_next = S_RESP;
                else if (idx_reg == AW'(1))   state_next = S_INS_PUT;
            end
            S_INS_PUT:  state_next = S_RESP;
            S_REM_SCAN: begin
                if (idx_reg == last_idx) state_next = S_RESP;
            end
            S_RD: begin
                if (out_free && idx_reg == last_idx) state_next = S_IDLE;
            end
            S_RESP: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        mem_we        = 1'b0;
        mem_wa        = idx_reg;
        mem_wd        = rdata_reg;
        mem_re        = 1'b0;
        mem_ra        = idx_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        op_id_next    = op_id_reg;
        op_pri_next   = op_pri_reg;
        st_next       = st_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_id_next     = m_id_reg;
        m_pri_next    = m_pri_reg;
        m_last_next   = m_last_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_id_next  = s_entry_id;
                    op_pri_next = s_priority_req;
                    found_next  = 1'b0;
                    st_next     = ST_OK;
                    case (s_mode)
                        MODE_INSERT: begin
                            if (is_full) begin
                                st_next = ST_FULL;
                            end else if (is_empty) begin
                                idx_next = '0;
                            end else begin
                                mem_re   = 1'b1;
                                mem_ra   = AW'(count_reg - CW'(1));
                                idx_next = AW'(count_reg);
                            end
                        end
                        MODE_REMOVE: begin
                            if (is_empty) begin
                                st_next = ST_NOT_FOUND;
                            end else begin
                                mem_re   = 1'b1;
                                mem_ra   = '0;
                                idx_next = '0;
                            end
                        end
                        MODE_READ: begin
                            if (is_empty) begin
                                st_next = ST_EMPTY;
                            end else begin
                                mem_re   = 1'b1;
                                mem_ra   = '0;
                                idx_next = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_INS_SCAN: begin
                // rdata holds entry idx-1; move it up or drop the new entry in
                mem_we = 1'b1;
                mem_wa = idx_reg;
                if (ins_stop) begin
                    mem_wd     = new_entry;
                    count_next = count_reg + CW'(1);
                end else begin
                    mem_wd   = rdata_reg;
                    idx_next = idx_reg - AW'(1);
                    if (idx_reg != AW'(1)) begin
                        mem_re = 1'b1;
                        mem_ra = idx_reg - AW'(2);
                    end
                end
            end
            S_INS_PUT: begin
                mem_we     = 1'b1;
                mem_wa     = idx_reg;
                mem_wd     = new_entry;
                count_next = count_reg + CW'(1);
            end
            S_REM_SCAN: begin
                // rdata holds entry idx; past the match, slide entries down
                if (found_reg) begin
                    mem_we = 1'b1;
                    mem_wa = idx_reg - AW'(1);
                    mem_wd = rdata_reg;
                end
                found_next = found_reg || id_match;
                if (idx_reg == last_idx) begin
                    if (found_reg || id_match) begin
                        count_next = count_reg - CW'(1);
                        st_next    = ST_OK;
                    end else begin
                        st_next = ST_NOT_FOUND;
                    end
                end else begin
                    mem_re   = 1'b1;
                    mem_ra   = idx_reg + AW'(1);
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_RD: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = ST_OK;
                    m_id_next     = rdata_reg.id;
                    m_pri_next    = rdata_reg.pri;
                    m_last_next   = (idx_reg == last_idx);
                    if (idx_reg != last_idx) begin
                        mem_re   = 1'b1;
                        mem_ra   = idx_reg + AW'(1);
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = st_reg;
                    m_id_next     = '0;
                    m_pri_next    = '0;
                    m_last_next   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        op_id_reg    <= op_id_next;
        op_pri_reg   <= op_pri_next;
        st_reg       <= st_next;
        m_status_reg <= m_status_next;
        m_id_reg     <= m_id_next;
        m_pri_reg    <= m_pri_next;
        m_last_reg   <= m_last_next;
    end

endmodule

[sv/spt_checker.sv]
module spt_checker
    import spt_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic [MODE_W-1:0]   s_mode,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STATUS_W-1:0] m_status,
    input logic [ID_W-1:0]     m_out_id,
    input logic [PRI_W-1:0]    m_out_priority,
    input logic                m_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_out_id)
            && $stable(m_out_priority) && $stable(m_last))
        else $error("result changed while stalled");

    // only a readout gives more than one result, all with status ok
    a_nonlast_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_status == ST_OK)
        else $error("non-final result without ok status");

    // error and empty results carry no entry and end the request
    a_err_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_last && m_out_id == '0
            && m_out_priority == '0)
        else $error("error result with entry data");

    // a real request keeps the block busy for at least the next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready
            && (s_mode == MODE_INSERT || s_mode == MODE_REMOVE || s_mode == MODE_READ)
            |=> !s_ready)
        else $error("request taken back to back");

endmodule

bind sorted_priority_table_core spt_checker u_spt_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_mode         (s_mode),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_out_id       (m_out_id),
    .m_out_priority (m_out_priority),
    .m_last         (m_last)
);

[bench/tb_top.sv]
module tb_top;
    import spt_pkg::*;

    // Table depth under test, and the request code the block must ignore.
    localparam int                TBL_CAP     = DEF_CAPACITY;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int RAND_ITEMS  = 160;
    localparam int IDLE_PCT    = 7;
    localparam int HOLD_LEN    = 300;    // receiver hold-off used to back up the block
    localparam int STALL_LIMIT = 4000;   // cycles with no transfer on either channel
    localparam int TAIL_CYCLES = 2 * TBL_CAP + 8;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [MODE_W-1:0]   s_mode         = MODE_INSERT;
    logic [ID_W-1:0]     s_entry_id     = '0;
    logic [PRI_W-1:0]    s_priority_req = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [ID_W-1:0]     m_out_id;
    logic [PRI_W-1:0]    m_out_priority;
    logic                m_last;

    // One result transfer as it should appear on the m_ channel.
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [PRI_W-1:0]    pri;
        logic                last;
    } table_result_t;

    // One row of the directed script. A row with reps > 1 is expanded into
    // consecutive inserts with stepped id and priority. A row marked typed
    // carries its single result by hand instead of taking it from the predictor.
    typedef struct {
        logic [MODE_W-1:0]   mode;
        logic [ID_W-1:0]     id;
        logic [PRI_W-1:0]    pri;
        int                  reps;
        bit                  typed;
        logic [STATUS_W-1:0] status;
    } script_row_t;

    sorted_priority_table_core #(
        .CAPACITY(TBL_CAP)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_entry_id    (s_entry_id),
        .s_priority_req(s_priority_req),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_out_id      (m_out_id),
        .m_out_priority(m_out_priority),
        .m_last        (m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the table, kept in step with every accepted request
    // ------------------------------------------------------------------
    logic [ID_W-1:0]  shadow_id  [TBL_CAP];
    logic [PRI_W-1:0] shadow_pri [TBL_CAP];
    int               shadow_count = 0;

    table_result_t expected_results[$];

    int fail_count      = 0;
    int results_checked = 0;
    int n_insert = 0, n_remove = 0, n_read = 0, n_ignored = 0;
    int n_full = 0, n_not_found = 0, n_empty = 0, peak_count = 0;

    // Shared with the receiver: calm_mode turns idling off on both sides,
    // holds_wanted asks the receiver for one long hold-off.
    bit calm_mode    = 1'b0;
    int holds_wanted = 0;
    int holds_done   = 0;

    // Applies one request to the shadow table and appends the results it
    // should produce. Insert goes behind strictly greater priorities only,
    // so it lands ahead of equal ones; remove drops the first id match.
    function automatic void predict_table_op(input logic [MODE_W-1:0] mode,
                                             input logic [ID_W-1:0] id,
                                             input logic [PRI_W-1:0] pri,
                                             ref table_result_t res[$]);
        int                  pos;
        logic [STATUS_W-1:0] st;
        pos = 0;
        case (mode)
            MODE_INSERT: begin
                n_insert++;
                if (shadow_count >= TBL_CAP) begin
                    st = ST_FULL;
                    n_full++;
                end else begin
                    while (pos < shadow_count && shadow_pri[pos] > pri)
                        pos++;
                    for (int i = shadow_count; i > pos; i--) begin
                        shadow_id[i]  = shadow_id[i-1];
                        shadow_pri[i] = shadow_pri[i-1];
                    end
                    shadow_id[pos]  = id;
                    shadow_pri[pos] = pri;
                    shadow_count++;
                    if (shadow_count > peak_count)
                        peak_count = shadow_count;
                    st = ST_OK;
                end
                res.push_back('{st, '0, '0, 1'b1});
            end
            MODE_REMOVE: begin
                n_remove++;
                while (pos < shadow_count && shadow_id[pos] != id)
                    pos++;
                if (pos >= shadow_count) begin
                    st = ST_NOT_FOUND;
                    n_not_found++;
                end else begin
                    for (int i = pos; i + 1 < shadow_count; i++) begin
                        shadow_id[i]  = shadow_id[i+1];
                        shadow_pri[i] = shadow_pri[i+1];
                    end
                    shadow_count--;
                    st = ST_OK;
                end
                res.push_back('{st, '0, '0, 1'b1});
            end
            MODE_READ: begin
                n_read++;
                if (shadow_count == 0) begin
                    n_empty++;
                    res.push_back('{ST_EMPTY, '0, '0, 1'b1});
                end else begin
                    for (int i = 0; i < shadow_count; i++)
                        res.push_back('{ST_OK, shadow_id[i], shadow_pri[i],
                                        (i + 1 == shadow_count)});
                end
            end
            default: n_ignored++;   // unused code: no result, no state change
        endcase
    endfunction

    // Presents one request and waits for its transfer. Prediction happens at
    // the accepting edge, so the shadow table always matches what the block
    // has taken so far.
    task automatic offer_request(input logic [MODE_W-1:0] mode,
                                 input logic [ID_W-1:0] id,
                                 input logic [PRI_W-1:0] pri,
                                 input bit typed,
                                 input logic [STATUS_W-1:0] status);
        table_result_t predicted[$];
        while (!calm_mode && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_entry_id     <= id;
        s_priority_req <= pri;
        do @(posedge aclk); while (!s_ready);
        predict_table_op(mode, id, pri, predicted);
        if (typed)
            expected_results.push_back('{status, '0, '0, 1'b1});
        else
            foreach (predicted[i]) expected_results.push_back(predicted[i]);
    endtask

    // ------------------------------------------------------------------
    // Result checker: every result transfer against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        table_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: status %0d id %h pri %h last %0d",
                       m_status, m_out_id, m_out_priority, m_last);
                fail_count++;
            end else begin
                exp_r = expected_results.pop_front();
                results_checked++;
                if (m_status !== exp_r.status) begin
                    $error("status: expected %0d, actual %0d", exp_r.status, m_status);
                    fail_count++;
                end
                if (m_out_id !== exp_r.id) begin
                    $error("out_id: expected %h, actual %h", exp_r.id, m_out_id);
                    fail_count++;
                end
                if (m_out_priority !== exp_r.pri) begin
                    $error("out_priority: expected %h, actual %h",
                           exp_r.pri, m_out_priority);
                    fail_count++;
                end
                if (m_last !== exp_r.last) begin
                    $error("last: expected %0d, actual %0d", exp_r.last, m_last);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, quiet stretches, and on request one
    // long hold-off so the block backs up and drops s_ready.
    // ------------------------------------------------------------------
    initial begin
        forever begin
            if (holds_done < holds_wanted) begin
                holds_done++;
                repeat (HOLD_LEN) begin
                    m_ready <= 1'b0;
                    @(posedge aclk);
                end
            end else begin
                m_ready <= calm_mode || ($urandom_range(99) >= IDLE_PCT);
                @(posedge aclk);
            end
        end
    end

    // Watchdog: too long without any transfer means the block is hung.
    int stall_cycles = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles, %0d results outstanding",
                     stall_cycles, expected_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed script, then random traffic
    // ------------------------------------------------------------------
    script_row_t script [18];

    initial begin
        int unsigned      roll;
        int               rand_sent;
        bit               drain;
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;

        script = '{
            // empty table: readout gives one empty status, remove misses
            '{MODE_READ,   16'h0000, 8'h00,  1, 1'b1, ST_EMPTY},
            '{MODE_REMOVE, 16'h1234, 8'h00,  1, 1'b1, ST_NOT_FOUND},
            // extremes of id and priority
            '{MODE_INSERT, 16'h0000, 8'h00,  1, 1'b1, ST_OK},
            '{MODE_INSERT, 16'hFFFF, 8'hFF,  1, 1'b1, ST_OK},
            '{MODE_INSERT, 16'h5555, 8'h80,  1, 1'b0, ST_OK},
            // equal priority goes ahead of the existing entry
            '{MODE_INSERT, 16'hAAAA, 8'h80,  1, 1'b0, ST_OK},
            // duplicate id, equal to the tail priority
            '{MODE_INSERT, 16'h5555, 8'h00,  1, 1'b0, ST_OK},
            '{MODE_READ,   16'h0000, 8'h00,  1, 1'b0, ST_OK},
            // first match only, then the tail entry, then the head entry
            '{MODE_REMOVE, 16'h5555, 8'h00,  1, 1'b0, ST_OK},
            '{MODE_REMOVE, 16'h0000, 8'h00,  1, 1'b0, ST_OK},
            '{MODE_REMOVE, 16'hFFFF, 8'h00,  1, 1'b0, ST_OK},
            '{MODE_UNUSED, 16'hFFFF, 8'hFF,  1, 1'b0, ST_OK},
            '{MODE_READ,   16'h0000, 8'h00,  1, 1'b0, ST_OK},
            '{MODE_REMOVE, 16'hFFFF, 8'h00,  1, 1'b1, ST_NOT_FOUND},
            // fill to capacity, then one insert too many
            '{MODE_INSERT, 16'h0100, 8'h05, 14, 1'b0, ST_OK},
            '{MODE_INSERT, 16'h7777, 8'h40,  1, 1'b1, ST_FULL},
            // full readout: the longest burst of results
            '{MODE_READ,   16'h0000, 8'h00,  1, 1'b0, ST_OK},
            '{MODE_REMOVE, 16'h0107, 8'h00,  1, 1'b0, ST_OK}
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[r]) begin
            for (int k = 0; k < script[r].reps; k++)
                offer_request(script[r].mode, script[r].id + ID_W'(k),
                              script[r].pri + PRI_W'(k * 19),
                              script[r].typed, script[r].status);
        end

        // Random part. Segments of 25 alternate between filling and draining
        // so the table keeps swinging between empty and full.
        rand_sent = 0;
        while (rand_sent < RAND_ITEMS) begin
            drain     = ((rand_sent / 25) % 2) == 1;
            calm_mode = (rand_sent >= 100 && rand_sent < 140);
            if (rand_sent == 60 && holds_wanted == 0)
                holds_wanted = 1;

            roll = $urandom_range(99);
            if (roll < 5)
                mode = MODE_UNUSED;
            else if (roll < 25)
                mode = MODE_READ;
            else if (roll < (drain ? 45 : 80))
                mode = MODE_INSERT;
            else
                mode = MODE_REMOVE;

            // removes mostly hit a live entry; small ids make duplicates likely
            if (mode == MODE_REMOVE && shadow_count > 0 && $urandom_range(99) < 80)
                id = shadow_id[$urandom_range(shadow_count - 1)];
            else if ($urandom_range(99) < 30)
                id = ID_W'($urandom_range(15));
            else
                id = ID_W'($urandom);

            if ($urandom_range(99) < 40)
                pri = PRI_W'($urandom_range(3) * 85);
            else
                pri = PRI_W'($urandom);

            offer_request(mode, id, pri, 1'b0, ST_OK);
            if (mode != MODE_UNUSED)
                rand_sent++;
        end
        s_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("requests: %0d insert, %0d remove, %0d readout, %0d unused code",
                 n_insert, n_remove, n_read, n_ignored);
        $display("%0d results checked; full %0d, not found %0d, empty %0d, peak %0d",
                 results_checked, n_full, n_not_found, n_empty, peak_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
